FILE: design/xlp_pkg.sv
// shared constants and types for the xor line predictor
package xlp_pkg;

    // line buffer depth and per-line byte limit
    localparam int XLP_MAX_LINE_BYTES = 1024;

    // register field widths
    localparam int MODE_W   = 2;
    localparam int WIDTH_W  = 14;
    localparam int HEIGHT_W = 16;
    localparam int BYTE_W   = 8;

    // bytes-per-line arithmetic width (holds up to 16383)
    localparam int LB_W = 14;

    // configuration bus
    localparam int PADDR_W = 4;
    localparam int PDATA_W = 32;

    // register indexes (paddr[3:2])
    localparam logic [1:0] REG_MODE      = 2'd0;
    localparam logic [1:0] REG_DIRECTION = 2'd1;
    localparam logic [1:0] REG_WIDTH     = 2'd2;
    localparam logic [1:0] REG_HEIGHT    = 2'd3;

    // prediction modes
    localparam logic [MODE_W-1:0] MODE_NONE = 2'd0;
    localparam logic [MODE_W-1:0] MODE_LEFT = 2'd1;
    localparam logic [MODE_W-1:0] MODE_UP   = 2'd2;

    // directions
    localparam logic DIR_FWD = 1'b0;
    localparam logic DIR_INV = 1'b1;

    // register reset values
    localparam logic [WIDTH_W-1:0]  WIDTH_RST  = 14'd8192;
    localparam logic [HEIGHT_W-1:0] HEIGHT_RST = 16'd1;

    // frame position flags for one word
    typedef struct packed {
        logic first_col;
        logic first_row;
        logic eol;
        logic eof;
    } xlp_pos_t;

endpackage

FILE: design/xlp_if.sv
// stream channel interfaces for input and coded words
interface xlp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] pixel_byte;

    modport source (output valid, output pixel_byte, input ready);
    modport sink   (input valid, input pixel_byte, output ready);
    modport mon    (input valid, input pixel_byte, input ready);
endinterface

interface xlp_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] coded_byte;
    logic       end_of_line;
    logic       end_of_frame;

    modport source (output valid, output coded_byte, output end_of_line,
                    output end_of_frame, input ready);
    modport sink   (input valid, input coded_byte, input end_of_line,
                    input end_of_frame, output ready);
    modport mon    (input valid, input coded_byte, input end_of_line,
                    input end_of_frame, input ready);
endinterface

FILE: design/xor_line_predictor.sv
// top level of the xor left/up line predictor
//
//  channel   dir  handshake       payload
//  pix_in    in   valid/ready     pixel_byte
//  coded_out out  valid/ready     coded_byte, end_of_line, end_of_frame
//  apb       in   psel/penable    paddr, pwdata -> mode, direction, width, height
//
//  one word per clock sustained while coded_out is not stalled; an accepted word passes
//  the input stage with line buffer read, then prediction into the output register
//  the line buffer has one read and one write port; a same-column write in the
//  accept cycle is forwarded around it
//  rst_n clears counters, left reference and valid flags; no line buffer clear
//  a stalled output holds its word; input keeps flowing while the input stage is free
module xor_line_predictor
    import xlp_pkg::*;
#(
    parameter int MAX_LINE_BYTES = XLP_MAX_LINE_BYTES
)(
    input  logic               clk,
    input  logic               rst_n,
    xlp_in_if.sink             pix_in,
    xlp_out_if.source          coded_out,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    localparam int COL_W = (MAX_LINE_BYTES > 1) ? $clog2(MAX_LINE_BYTES) : 1;

    logic [MODE_W-1:0]   mode_reg;
    logic                direction_reg;
    logic [WIDTH_W-1:0]  width_reg;
    logic [HEIGHT_W-1:0] height_reg;
    logic                cfg_wr;

    logic                accept;
    logic                s1_adv;
    logic [COL_W-1:0]    pos_col;
    xlp_pos_t            pos;

    logic                s1_valid_reg;
    logic [BYTE_W-1:0]   s1_byte_reg;
    logic [COL_W-1:0]    s1_col_reg;
    xlp_pos_t            s1_pos_reg;
    logic                s1_byp_reg;
    logic [BYTE_W-1:0]   s1_byp_data_reg;
    logic                byp_next;

    logic [BYTE_W-1:0]   rd_data;
    logic [BYTE_W-1:0]   row_ref;
    logic [BYTE_W-1:0]   left_ref_reg;
    logic [BYTE_W-1:0]   res;
    logic [BYTE_W-1:0]   ref_val;

    logic                out_valid_reg;
    logic [BYTE_W-1:0]   out_byte_reg;
    logic                out_eol_reg;
    logic                out_eof_reg;

    // configuration registers
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= MODE_NONE;
            direction_reg <= DIR_FWD;
            width_reg     <= WIDTH_RST;
            height_reg    <= HEIGHT_RST;
        end
        else if (cfg_wr)
        begin
            case (paddr[3:2])
                REG_MODE:      mode_reg      <= pwdata[MODE_W-1:0];
                REG_DIRECTION: direction_reg <= pwdata[0];
                REG_WIDTH:     width_reg     <= pwdata[WIDTH_W-1:0];
                REG_HEIGHT:    height_reg    <= pwdata[HEIGHT_W-1:0];
                default:       mode_reg      <= mode_reg;
            endcase
        end
    end

    // register readback
    always_comb
    begin
        case (paddr[3:2])
            REG_MODE:      prdata = PDATA_W'(mode_reg);
            REG_DIRECTION: prdata = PDATA_W'(direction_reg);
            REG_WIDTH:     prdata = PDATA_W'(width_reg);
            REG_HEIGHT:    prdata = PDATA_W'(height_reg);
            default:       prdata = '0;
        endcase
    end

    // handshake: input stage moves on when the output register is free
    assign s1_adv       = s1_valid_reg && (!out_valid_reg || coded_out.ready);
    assign pix_in.ready = !s1_valid_reg || s1_adv;
    assign accept       = pix_in.valid && pix_in.ready;

    // frame position
    xlp_position #(
        .MAX_LINE_BYTES (MAX_LINE_BYTES),
        .COL_W          (COL_W)
    ) u_position (
        .clk                (clk),
        .rst_n              (rst_n),
        .step               (accept),
        .frame_width_pixels (width_reg),
        .frame_height_lines (height_reg),
        .col                (pos_col),
        .pos                (pos)
    );

    // row above, read at accept and written when the word leaves the input stage
    xlp_line_buf #(
        .DEPTH (MAX_LINE_BYTES),
        .AW    (COL_W)
    ) u_line_buf (
        .clk     (clk),
        .rd_en   (accept),
        .rd_addr (pos_col),
        .rd_data (rd_data),
        .wr_en   (s1_adv),
        .wr_addr (s1_col_reg),
        .wr_data (ref_val)
    );

    // forward a same-column write that lands in the read cycle
    assign byp_next = s1_adv && (s1_col_reg == pos_col);

    // input stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (s1_adv)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_byte_reg     <= pix_in.pixel_byte;
            s1_col_reg      <= pos_col;
            s1_pos_reg      <= pos;
            s1_byp_reg      <= byp_next;
            s1_byp_data_reg <= ref_val;
        end
    end

    // prediction
    assign row_ref = s1_byp_reg ? s1_byp_data_reg : rd_data;

    always_comb
    begin
        case (mode_reg)
            MODE_LEFT:
                res = s1_pos_reg.first_col ? s1_byte_reg : (s1_byte_reg ^ left_ref_reg);
            MODE_UP:
                res = s1_pos_reg.first_row ? s1_byte_reg : (s1_byte_reg ^ row_ref);
            default:
                res = s1_byte_reg;
        endcase
        ref_val = (direction_reg == DIR_INV) ? res : s1_byte_reg;
    end

    // left reference
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_ref_reg <= '0;
        end
        else if (s1_adv)
        begin
            left_ref_reg <= ref_val;
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_adv)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (coded_out.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv)
        begin
            out_byte_reg <= res;
            out_eol_reg  <= s1_pos_reg.eol;
            out_eof_reg  <= s1_pos_reg.eof;
        end
    end

    assign coded_out.valid        = out_valid_reg;
    assign coded_out.coded_byte   = out_byte_reg;
    assign coded_out.end_of_line  = out_eol_reg;
    assign coded_out.end_of_frame = out_eof_reg;

endmodule

FILE: design/xlp_line_buf.sv
// single-port-write, single-port-read line buffer with registered read data
module xlp_line_buf
    import xlp_pkg::*;
#(
    parameter int DEPTH = XLP_MAX_LINE_BYTES,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
)(
    input  logic              clk,
    input  logic              rd_en,
    input  logic [AW-1:0]     rd_addr,
    output logic [BYTE_W-1:0] rd_data,
    input  logic              wr_en,
    input  logic [AW-1:0]     wr_addr,
    input  logic [BYTE_W-1:0] wr_data
);

    logic [BYTE_W-1:0] mem [DEPTH];
    logic [BYTE_W-1:0] rd_data_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // read port, old data on same-address collision
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: design/xlp_position.sv
// column and row counters with end of line and end of frame flags
module xlp_position
    import xlp_pkg::*;
#(
    parameter int MAX_LINE_BYTES = XLP_MAX_LINE_BYTES,
    parameter int COL_W = (MAX_LINE_BYTES > 1) ? $clog2(MAX_LINE_BYTES) : 1
)(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                step,
    input  logic [WIDTH_W-1:0]  frame_width_pixels,
    input  logic [HEIGHT_W-1:0] frame_height_lines,
    output logic [COL_W-1:0]    col,
    output xlp_pos_t            pos
);

    localparam logic [LB_W-1:0] MAX_LB = LB_W'(MAX_LINE_BYTES);

    logic [COL_W-1:0]    col_reg, col_next;
    logic [HEIGHT_W-1:0] row_reg, row_next;
    logic [WIDTH_W:0]    width_sum;
    logic [LB_W-1:0]     raw_bytes;
    logic [LB_W-1:0]     line_bytes;
    logic [HEIGHT_W:0]   height;
    logic [LB_W-1:0]     col_plus;
    logic [HEIGHT_W:0]   row_plus;
    logic                eol;
    logic                eof;

    // bytes per line: ceil(width / 8), at least one, at most the buffer
    always_comb
    begin
        width_sum = {1'b0, frame_width_pixels} + (WIDTH_W+1)'(7);
        raw_bytes = LB_W'(width_sum[WIDTH_W:3]);
        if (raw_bytes == '0)
        begin
            line_bytes = LB_W'(1);
        end
        else if (raw_bytes > MAX_LB)
        begin
            line_bytes = MAX_LB;
        end
        else
        begin
            line_bytes = raw_bytes;
        end
        height = (frame_height_lines == '0) ? (HEIGHT_W+1)'(1)
                                            : {1'b0, frame_height_lines};
    end

    // end flags and next counts
    always_comb
    begin
        col_plus = LB_W'(col_reg) + LB_W'(1);
        row_plus = {1'b0, row_reg} + (HEIGHT_W+1)'(1);
        eol      = (col_plus >= line_bytes);
        eof      = eol && (row_plus >= height);
        if (eol)
        begin
            col_next = '0;
            row_next = eof ? '0 : row_plus[HEIGHT_W-1:0];
        end
        else
        begin
            col_next = COL_W'(col_plus);
            row_next = row_reg;
        end
    end

    // counters advance on each accepted word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (step)
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    assign col           = col_reg;
    assign pos.first_col = (col_reg == '0);
    assign pos.first_row = (row_reg == '0);
    assign pos.eol       = eol;
    assign pos.eof       = eof;

endmodule

FILE: design/xlp_checker.sv
// port-level checks for the xor line predictor and their bind
module xlp_checker
    import xlp_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              pix_valid,
    input  logic              pix_ready,
    input  logic              coded_valid,
    input  logic              coded_ready,
    input  logic [BYTE_W-1:0] coded_byte,
    input  logic              end_of_line,
    input  logic              end_of_frame,
    input  logic              pready
);

    // a stalled result word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        coded_valid && !coded_ready |=>
            coded_valid && $stable(coded_byte)
            && $stable(end_of_line) && $stable(end_of_frame))
        else $error("stalled output word changed");

    // end of frame only on the last word of a line
    a_eof_eol: assert property (@(posedge clk) disable iff (!rst_n)
        coded_valid && end_of_frame |-> end_of_line)
        else $error("end of frame without end of line");

    // an accepted word reaches the output when the output side keeps taking words
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        pix_valid && pix_ready && coded_ready ##1 coded_ready
            |=> coded_valid)
        else $error("accepted word did not reach the output in two cycles");

    // configuration port never waits
    a_pready: assert property (@(posedge clk) disable iff (!rst_n)
        pready)
        else $error("pready low");

endmodule

bind xor_line_predictor xlp_checker u_xlp_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .pix_valid    (pix_in.valid),
    .pix_ready    (pix_in.ready),
    .coded_valid  (coded_out.valid),
    .coded_ready  (coded_out.ready),
    .coded_byte   (coded_out.coded_byte),
    .end_of_line  (coded_out.end_of_line),
    .end_of_frame (coded_out.end_of_frame),
    .pready       (pready)
);
